/* rtl/monotone_tangent_calculator_unit_defines.svh */
// Assertion helpers for the file that checks the tangent calculator.
`ifndef MONOTONE_TANGENT_CALCULATOR_UNIT_DEFINES_SVH
`define MONOTONE_TANGENT_CALCULATOR_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on clk_i and disabled while rst_ni is low.
`define MTC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i and disabled while rst_ni is low.
`define MTC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/mtc_pkg.sv */
package mtc_pkg;

  // Operations of the shared arithmetic unit.
  typedef enum logic [1:0] {
    OP_MUL,
    OP_DIV,
    OP_SQRT
  } unit_op_e;

  // Request from the sequencer to the shared unit.
  typedef struct packed {
    logic        start;
    unit_op_e    op;
    logic [63:0] opa;
    logic [31:0] opb;
  } unit_req_t;

  // Response of the shared unit; result holds until the next start.
  typedef struct packed {
    logic        done;
    logic [63:0] result;
  } unit_rsp_t;

  // Register index of flat_threshold, taken from paddr[2].
  localparam logic REG_FLAT_THRESHOLD = 1'b0;

  // Reset value of flat_threshold.
  localparam logic [15:0] FLAT_THRESHOLD_RST = 16'd1;

endpackage

/* rtl/mtc_unit.sv */
module mtc_unit (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  mtc_pkg::unit_req_t req_i,
  output mtc_pkg::unit_rsp_t rsp_o
);

  mtc_pkg::unit_op_e op_q, op_d;
  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic [5:0]        cnt_q, cnt_d;
  logic [63:0]       sh_q, sh_d;
  logic [33:0]       rem_q, rem_d;
  logic [31:0]       root_q, root_d;
  logic [31:0]       dv_q, dv_d;

  logic [32:0] div_t;
  logic        div_ge;
  logic [32:0] div_rem;
  logic [34:0] sq_t;
  logic [34:0] sq_trial;
  logic        sq_ge;
  logic [34:0] sq_rem;

  // Restoring divide step: one quotient bit per cycle.
  assign div_t   = {rem_q[31:0], sh_q[63]};
  assign div_ge  = div_t >= {1'b0, dv_q};
  assign div_rem = div_ge ? (div_t - {1'b0, dv_q}) : div_t;

  // Digit-by-digit square root step: one root bit per cycle.
  assign sq_t     = {rem_q[32:0], sh_q[63:62]};
  assign sq_trial = {1'b0, root_q, 2'b01};
  assign sq_ge    = sq_t >= sq_trial;
  assign sq_rem   = sq_ge ? (sq_t - sq_trial) : sq_t;

  // Operation sequencing.
  always_comb begin
    op_d   = op_q;
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    sh_d   = sh_q;
    rem_d  = rem_q;
    root_d = root_q;
    dv_d   = dv_q;
    if (req_i.start) begin
      op_d = req_i.op;
      case (req_i.op)
        mtc_pkg::OP_MUL: begin
          sh_d   = 64'(req_i.opa[31:0]) * 64'(req_i.opb);
          done_d = 1'b1;
        end
        mtc_pkg::OP_DIV: begin
          sh_d   = req_i.opa;
          dv_d   = req_i.opb;
          rem_d  = '0;
          cnt_d  = 6'd63;
          busy_d = 1'b1;
        end
        mtc_pkg::OP_SQRT: begin
          sh_d   = req_i.opa;
          rem_d  = '0;
          root_d = '0;
          cnt_d  = 6'd31;
          busy_d = 1'b1;
        end
        default: begin
          done_d = 1'b1;
        end
      endcase
    end else if (busy_q) begin
      case (op_q)
        mtc_pkg::OP_DIV: begin
          rem_d = 34'(div_rem[31:0]);
          sh_d  = {sh_q[62:0], div_ge};
        end
        mtc_pkg::OP_SQRT: begin
          rem_d  = sq_rem[33:0];
          root_d = {root_q[30:0], sq_ge};
          sh_d   = {sh_q[61:0], 2'b00};
        end
        default: begin
          rem_d = rem_q;
        end
      endcase
      cnt_d = cnt_q - 6'd1;
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      op_q   <= mtc_pkg::OP_MUL;
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      op_q   <= op_d;
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sh_q   <= sh_d;
    rem_q  <= rem_d;
    root_q <= root_d;
    dv_q   <= dv_d;
  end

  assign rsp_o.done   = done_q;
  assign rsp_o.result = (op_q == mtc_pkg::OP_SQRT) ? {32'd0, root_q} : sh_q;

endmodule

/* rtl/mtc_ctrl.sv */
module mtc_ctrl #(
  parameter int unsigned MAX_POINTS = 64
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic [15:0]        flat_threshold_i,
  input  logic signed [31:0] knot_x_i,
  input  logic signed [31:0] knot_y_i,
  input  logic               final_knot_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  output logic [5:0]         knot_index_o,
  output logic signed [31:0] slope_o,
  output logic               run_end_o,
  output logic               spacing_error_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output mtc_pkg::unit_req_t unit_req_o,
  input  mtc_pkg::unit_rsp_t unit_rsp_i
);

  localparam int unsigned IW = $clog2(MAX_POINTS);
  localparam logic [IW-1:0] LastIdx = IW'(MAX_POINTS - 1);

  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_SDIV = 4'd1;
  localparam logic [3:0] ST_AVG  = 4'd2;
  localparam logic [3:0] ST_NEXT = 4'd3;
  localparam logic [3:0] ST_LD0  = 4'd4;
  localparam logic [3:0] ST_LD   = 4'd5;
  localparam logic [3:0] ST_MA   = 4'd6;
  localparam logic [3:0] ST_MB   = 4'd7;
  localparam logic [3:0] ST_MS   = 4'd8;
  localparam logic [3:0] ST_SQ   = 4'd9;
  localparam logic [3:0] ST_MDA  = 4'd10;
  localparam logic [3:0] ST_DVA  = 4'd11;
  localparam logic [3:0] ST_MDB  = 4'd12;
  localparam logic [3:0] ST_DVB  = 4'd13;
  localparam logic [3:0] ST_FIN  = 4'd14;
  localparam logic [3:0] ST_EMIT = 4'd15;

  function automatic logic [31:0] mag32(input logic [31:0] v);
    mag32 = v[31] ? (~v + 32'd1) : v;
  endfunction

  function automatic logic is_flat(input logic [31:0] v, input logic [15:0] thr);
    is_flat = mag32(v) < {16'd0, thr};
  endfunction

  function automatic logic [31:0] with_sign(input logic neg, input logic [31:0] q);
    with_sign = neg ? (~q + 32'd1) : q;
  endfunction

  logic [3:0]    state_q, state_d;
  logic [IW-1:0] cnt_q, cnt_d;
  logic [IW-1:0] k_q, k_d;
  logic [IW-1:0] i_q, i_d;
  logic          last_q, last_d;
  logic          err_q, err_d;
  logic          neg_q, neg_d;
  logic [31:0]   px_q, px_d;
  logic [31:0]   py_q, py_d;
  logic [31:0]   sec_new_q, sec_new_d;
  logic [31:0]   sec_prev_q, sec_prev_d;
  logic [31:0]   s0_q, s0_d;
  logic [31:0]   s1_q, s1_d;
  logic [31:0]   cur_q, cur_d;
  logic [31:0]   b_q, b_d;
  logic [63:0]   sum_q, sum_d;
  logic [31:0]   r_q, r_d;
  logic [IW-1:0] out_idx_q, out_idx_d;
  logic [31:0]   out_slope_q, out_slope_d;
  logic          out_end_q, out_end_d;

  // Slope and secant stores, read through registers.
  logic [31:0]   sec_mem [MAX_POINTS];
  logic [31:0]   slope_mem [MAX_POINTS];
  logic [31:0]   sec_rd_q;
  logic [31:0]   slope_rd_q;
  logic          sec_we;
  logic          slope_we;
  logic [IW-1:0] waddr;
  logic [IW-1:0] raddr;

  logic [32:0] dx;
  logic [32:0] dy;
  logic [32:0] dy_abs;
  logic        dx_nonpos;
  logic        last_in;
  logic [32:0] avg_sum;
  logic [32:0] avg_adj;
  logic [31:0] avg_val;
  logic [63:0] sec_q64;
  logic [31:0] sec_sat;
  logic [31:0] b_flat;
  logic [66:0] nine_p;
  logic [63:0] three_p;
  logic [IW:0] i_next_w;

  // Differences against the previous knot.
  assign dx        = {knot_x_i[31], knot_x_i} - {px_q[31], px_q};
  assign dy        = {knot_y_i[31], knot_y_i} - {py_q[31], py_q};
  assign dy_abs    = dy[32] ? (~dy + 33'd1) : dy;
  assign dx_nonpos = dx[32] || (dx == '0);
  assign last_in   = final_knot_i || (cnt_q == LastIdx);

  // Interior slope: mean of adjacent secants, truncated toward zero.
  assign avg_sum = {sec_prev_q[31], sec_prev_q} + {sec_new_q[31], sec_new_q};
  assign avg_adj = avg_sum + 33'(avg_sum[32]);
  assign avg_val = avg_adj[32:1];

  // Secant quotient magnitude saturated to the signed range.
  assign sec_q64 = unit_rsp_i.result;
  always_comb begin
    if (neg_q) begin
      sec_sat = (sec_q64 > 64'h0000_0000_8000_0000) ? 32'h8000_0000
                                                    : with_sign(1'b1, sec_q64[31:0]);
    end else begin
      sec_sat = (sec_q64 > 64'h0000_0000_7FFF_FFFF) ? 32'h7FFF_FFFF : sec_q64[31:0];
    end
  end

  // Near-flat secants on either side zero the next knot's slope; secant 0 is never tested.
  assign b_flat = (is_flat(sec_rd_q, flat_threshold_i) ||
                   ((i_q != '0) && is_flat(s0_q, flat_threshold_i))) ? '0 : slope_rd_q;

  assign nine_p   = {3'b000, unit_rsp_i.result} + {unit_rsp_i.result, 3'b000};
  assign three_p  = {unit_rsp_i.result[62:0], 1'b0} + unit_rsp_i.result;
  assign i_next_w = {1'b0, i_q} + {{IW{1'b0}}, 1'b1};

  assign waddr = k_q - {{(IW-1){1'b0}}, 1'b1};
  assign raddr = ((state_q == ST_NEXT) && (i_q == '0)) ? '0 : i_next_w[IW-1:0];

  // Sequencer.
  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    k_d         = k_q;
    i_d         = i_q;
    last_d      = last_q;
    err_d       = err_q;
    neg_d       = neg_q;
    px_d        = px_q;
    py_d        = py_q;
    sec_new_d   = sec_new_q;
    sec_prev_d  = sec_prev_q;
    s0_d        = s0_q;
    s1_d        = s1_q;
    cur_d       = cur_q;
    b_d         = b_q;
    sum_d       = sum_q;
    r_d         = r_q;
    out_idx_d   = out_idx_q;
    out_slope_d = out_slope_q;
    out_end_d   = out_end_q;
    sec_we      = 1'b0;
    slope_we    = 1'b0;
    unit_req_o  = '{start: 1'b0, op: mtc_pkg::OP_MUL, opa: '0, opb: '0};
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          px_d   = knot_x_i;
          py_d   = knot_y_i;
          k_d    = cnt_q;
          last_d = last_in;
          cnt_d  = cnt_q + {{(IW-1){1'b0}}, 1'b1};
          if (cnt_q != '0) begin
            if (dx_nonpos) begin
              err_d     = 1'b1;
              sec_new_d = '0;
              state_d   = ST_AVG;
            end else begin
              neg_d      = dy[32];
              unit_req_o = '{start: 1'b1, op: mtc_pkg::OP_DIV,
                             opa: {16'd0, dy_abs[31:0], 16'd0}, opb: dx[31:0]};
              state_d    = ST_SDIV;
            end
          end else if (last_in) begin
            i_d     = '0;
            cur_d   = '0;
            state_d = ST_NEXT;
          end
        end
      end
      ST_SDIV: begin
        if (unit_rsp_i.done) begin
          sec_new_d = sec_sat;
          state_d   = ST_AVG;
        end
      end
      ST_AVG: begin
        sec_we     = 1'b1;
        slope_we   = k_q > {{(IW-1){1'b0}}, 1'b1};
        sec_prev_d = sec_new_q;
        if (last_q) begin
          i_d     = '0;
          cur_d   = '0;
          state_d = ST_NEXT;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_NEXT: begin
        if (i_next_w < {1'b0, k_q}) begin
          state_d = (i_q == '0) ? ST_LD0 : ST_LD;
        end else begin
          out_idx_d   = i_q;
          out_end_d   = (i_q == k_q);
          out_slope_d = (i_q == k_q) ? '0 : cur_q;
          i_d         = i_next_w[IW-1:0];
          state_d     = ST_EMIT;
        end
      end
      ST_LD0: begin
        s0_d    = sec_rd_q;
        state_d = ST_LD;
      end
      ST_LD: begin
        s1_d = sec_rd_q;
        b_d  = b_flat;
        if ((s0_q == '0) || (sec_rd_q == '0) || (s0_q[31] != sec_rd_q[31])) begin
          cur_d   = '0;
          b_d     = '0;
          state_d = ST_FIN;
        end else begin
          unit_req_o = '{start: 1'b1, op: mtc_pkg::OP_MUL,
                         opa: {32'd0, mag32(cur_q)}, opb: mag32(cur_q)};
          state_d    = ST_MA;
        end
      end
      ST_MA: begin
        if (unit_rsp_i.done) begin
          sum_d      = unit_rsp_i.result;
          unit_req_o = '{start: 1'b1, op: mtc_pkg::OP_MUL,
                         opa: {32'd0, mag32(b_q)}, opb: mag32(b_q)};
          state_d    = ST_MB;
        end
      end
      ST_MB: begin
        if (unit_rsp_i.done) begin
          sum_d      = sum_q + unit_rsp_i.result;
          unit_req_o = '{start: 1'b1, op: mtc_pkg::OP_MUL,
                         opa: {32'd0, mag32(s0_q)}, opb: mag32(s0_q)};
          state_d    = ST_MS;
        end
      end
      ST_MS: begin
        // Rescale only when a^2 + b^2 exceeds nine times the secant squared.
        if (unit_rsp_i.done) begin
          if ({3'b000, sum_q} > nine_p) begin
            unit_req_o = '{start: 1'b1, op: mtc_pkg::OP_SQRT, opa: sum_q, opb: '0};
            state_d    = ST_SQ;
          end else begin
            state_d = ST_FIN;
          end
        end
      end
      ST_SQ: begin
        if (unit_rsp_i.done) begin
          r_d        = unit_rsp_i.result[31:0];
          unit_req_o = '{start: 1'b1, op: mtc_pkg::OP_MUL,
                         opa: {32'd0, mag32(cur_q)}, opb: mag32(s0_q)};
          state_d    = ST_MDA;
        end
      end
      ST_MDA: begin
        if (unit_rsp_i.done) begin
          unit_req_o = '{start: 1'b1, op: mtc_pkg::OP_DIV, opa: three_p, opb: r_q};
          state_d    = ST_DVA;
        end
      end
      ST_DVA: begin
        if (unit_rsp_i.done) begin
          cur_d      = with_sign(cur_q[31], unit_rsp_i.result[31:0]);
          unit_req_o = '{start: 1'b1, op: mtc_pkg::OP_MUL,
                         opa: {32'd0, mag32(b_q)}, opb: mag32(s0_q)};
          state_d    = ST_MDB;
        end
      end
      ST_MDB: begin
        if (unit_rsp_i.done) begin
          unit_req_o = '{start: 1'b1, op: mtc_pkg::OP_DIV, opa: three_p, opb: r_q};
          state_d    = ST_DVB;
        end
      end
      ST_DVB: begin
        if (unit_rsp_i.done) begin
          b_d     = with_sign(b_q[31], unit_rsp_i.result[31:0]);
          state_d = ST_FIN;
        end
      end
      ST_FIN: begin
        // The slope of knot i is final; the next knot's slope carries over.
        out_idx_d   = i_q;
        out_slope_d = cur_q;
        out_end_d   = 1'b0;
        cur_d       = b_q;
        s0_d        = s1_q;
        i_d         = i_next_w[IW-1:0];
        state_d     = ST_EMIT;
      end
      ST_EMIT: begin
        if (out_ready_i) begin
          if (out_end_q) begin
            cnt_d   = '0;
            err_d   = 1'b0;
            state_d = ST_IDLE;
          end else begin
            state_d = ST_NEXT;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
      k_q     <= '0;
      i_q     <= '0;
      last_q  <= 1'b0;
      err_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      k_q     <= k_d;
      i_q     <= i_d;
      last_q  <= last_d;
      err_q   <= err_d;
    end
  end

  always_ff @(posedge clk_i) begin
    neg_q       <= neg_d;
    px_q        <= px_d;
    py_q        <= py_d;
    sec_new_q   <= sec_new_d;
    sec_prev_q  <= sec_prev_d;
    s0_q        <= s0_d;
    s1_q        <= s1_d;
    cur_q       <= cur_d;
    b_q         <= b_d;
    sum_q       <= sum_d;
    r_q         <= r_d;
    out_idx_q   <= out_idx_d;
    out_slope_q <= out_slope_d;
    out_end_q   <= out_end_d;
  end

  // Store writes and registered reads.
  always_ff @(posedge clk_i) begin
    if (sec_we) begin
      sec_mem[waddr] <= sec_new_q;
    end
    if (slope_we) begin
      slope_mem[waddr] <= avg_val;
    end
    sec_rd_q   <= sec_mem[raddr];
    slope_rd_q <= slope_mem[raddr];
  end

  assign in_ready_o      = (state_q == ST_IDLE);
  assign out_valid_o     = (state_q == ST_EMIT);
  assign knot_index_o    = 6'(out_idx_q);
  assign slope_o         = out_slope_q;
  assign run_end_o       = out_end_q;
  assign spacing_error_o = err_q;

endmodule

/* rtl/monotone_tangent_calculator_unit.sv */
// Channel   Handshake                 Payload
// input     in_valid_i / in_ready_o   knot_x_i, knot_y_i, final_knot_i
// output    out_valid_o / out_ready_i knot_index_o, slope_o, run_end_o, spacing_error_o
// config    APB write, pready high    paddr, pwdata (flat_threshold at 0x0)
//
// A knot after the first runs one 64-step divide for its secant, unless its x does not rise.
// After the final knot each pass over a secant pair uses the shared unit for up to
// three multiplies, a 32-step square root, two multiplies and two 64-step divides.
// One result is offered per pass; a stalled output transfer holds the sequencer.
// Reset clears the knot count, the error flag and the unit; flat_threshold resets to 1.
module monotone_tangent_calculator_unit #(
  parameter int unsigned MAX_POINTS = 64
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic signed [31:0] knot_x_i,
  input  logic signed [31:0] knot_y_i,
  input  logic               final_knot_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  output logic [5:0]         knot_index_o,
  output logic signed [31:0] slope_o,
  output logic               run_end_o,
  output logic               spacing_error_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  logic [15:0]        thr_q, thr_d;
  mtc_pkg::unit_req_t unit_req;
  mtc_pkg::unit_rsp_t unit_rsp;

  // Configuration register write and read-back.
  always_comb begin
    thr_d = thr_q;
    if (psel && penable && pwrite && (paddr[2] == mtc_pkg::REG_FLAT_THRESHOLD)) begin
      thr_d = pwdata[15:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= mtc_pkg::FLAT_THRESHOLD_RST;
    end else begin
      thr_q <= thr_d;
    end
  end

  assign prdata = (paddr[2] == mtc_pkg::REG_FLAT_THRESHOLD) ? {16'd0, thr_q} : '0;
  assign pready = 1'b1;

  mtc_ctrl #(
    .MAX_POINTS(MAX_POINTS)
  ) u_ctrl (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .flat_threshold_i(thr_q),
    .knot_x_i        (knot_x_i),
    .knot_y_i        (knot_y_i),
    .final_knot_i    (final_knot_i),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .knot_index_o    (knot_index_o),
    .slope_o         (slope_o),
    .run_end_o       (run_end_o),
    .spacing_error_o (spacing_error_o),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .unit_req_o      (unit_req),
    .unit_rsp_i      (unit_rsp)
  );

  mtc_unit u_unit (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (unit_req),
    .rsp_o (unit_rsp)
  );

  // Checks on sequencing.
`include "monotone_tangent_calculator_unit_defines.svh"

  `MTC_ASSERT_NOW(a_result_blocks_input, out_valid_o, !in_ready_o, "input open during a result")
  `MTC_ASSERT_NEXT(a_final_starts_run, in_valid_i && in_ready_o && final_knot_i, !in_ready_o, "final knot did not start the run")
  `MTC_ASSERT_NEXT(a_run_end_returns, out_valid_o && out_ready_i && run_end_o, in_ready_o, "not idle after the last transfer")

endmodule

/* bench/monotone_tangent_calculator_unit_tb.sv */
module monotone_tangent_calculator_unit_tb;

  localparam int unsigned MaxKnots = 64;

  // One knot as the sender presents it.
  typedef struct {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic               last;
  } knot_t;

  // One tangent as the block should report it.
  typedef struct {
    logic [5:0]         index;
    logic signed [31:0] slope;
    logic               run_end;
    logic               spacing_err;
  } tangent_t;

  logic               clk_i;
  logic               rst_ni;
  logic signed [31:0] knot_x_i;
  logic signed [31:0] knot_y_i;
  logic               final_knot_i;
  logic               in_valid_i;
  logic               in_ready_o;
  logic [5:0]         knot_index_o;
  logic signed [31:0] slope_o;
  logic               run_end_o;
  logic               spacing_error_o;
  logic               out_valid_o;
  logic               out_ready_i;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [2:0]         paddr;
  logic [31:0]        pwdata;
  logic [31:0]        prdata;
  logic               pready;

  knot_t    pending_knots[$];
  tangent_t expected_tangents[$];
  int       errors;
  int       knots_sent;
  int       tangents_seen;
  int       runs_done;

  // Predictor state.
  logic signed [31:0] pred_x[MaxKnots];
  logic signed [31:0] pred_y[MaxKnots];
  int                 pred_count;
  bit                 pred_error;
  logic [15:0]        pred_flat;

  monotone_tangent_calculator_unit #(
    .MAX_POINTS(MaxKnots)
  ) i_dut (
    .clk_i, .rst_ni, .knot_x_i, .knot_y_i, .final_knot_i, .in_valid_i, .in_ready_o,
    .knot_index_o, .slope_o, .run_end_o, .spacing_error_o, .out_valid_o, .out_ready_i,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  always #5 clk_i = ~clk_i;

  function automatic longint unsigned abs64(longint v);
    return (v < 0) ? longint'(-v) : longint'(v);
  endfunction

  function automatic logic signed [31:0] clamp32(longint v);
    if (v > 64'sd2147483647) return 32'sh7fffffff;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned res;
    longint unsigned bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  function automatic logic signed [31:0] shrink_tangent(logic signed [31:0] d,
                                                         longint unsigned sm,
                                                         longint unsigned r);
    longint unsigned q;
    q = (3 * abs64(d) * sm) / r;
    return (d < 0) ? -longint'(q) : longint'(q);
  endfunction

  // Computes the tangents of a whole run and queues them.
  task automatic compute_tangents(int n);
    logic signed [31:0] sec[MaxKnots];
    logic signed [31:0] tan[MaxKnots];
    longint             dx;
    longint             dy;
    longint unsigned    sm;
    longint unsigned    a;
    longint unsigned    b;
    longint unsigned    sum;
    longint unsigned    r;
    tangent_t           t;
    for (int i = 0; i + 1 < n; i++) begin
      dx = longint'(pred_x[i+1]) - longint'(pred_x[i]);
      dy = longint'(pred_y[i+1]) - longint'(pred_y[i]);
      sec[i] = (dx <= 0) ? 32'sd0 : clamp32((dy * 65536) / dx);
    end
    tan[0] = 0;
    for (int i = 1; i + 1 < n; i++) tan[i] = (longint'(sec[i-1]) + longint'(sec[i])) / 2;
    tan[n-1] = 0;
    for (int i = 1; i + 1 < n; i++) begin
      if (abs64(sec[i]) < pred_flat) begin
        tan[i] = 0;
        tan[i+1] = 0;
      end
    end
    // Fritsch-Carlson pass: zero at sign changes and zero secants, rescale steep pairs.
    for (int i = 0; i + 2 < n; i++) begin
      if (sec[i] == 0 || sec[i+1] == 0 || ((sec[i] < 0) != (sec[i+1] < 0))) begin
        tan[i] = 0;
        tan[i+1] = 0;
      end else begin
        sm = abs64(sec[i]);
        a = abs64(tan[i]);
        b = abs64(tan[i+1]);
        sum = a * a + b * b;
        if ((sum + 8) / 9 > sm * sm) begin
          r = int_sqrt(sum);
          tan[i] = shrink_tangent(tan[i], sm, r);
          tan[i+1] = shrink_tangent(tan[i+1], sm, r);
        end
      end
    end
    tan[n-1] = 0;
    for (int i = 0; i < n; i++) begin
      t.index = i[5:0];
      t.slope = tan[i];
      t.run_end = (i + 1 == n);
      t.spacing_err = pred_error;
      expected_tangents.push_back(t);
    end
  endtask

  // Loads one accepted knot into the predictor.
  task automatic absorb_knot(knot_t k);
    int idx;
    idx = (pred_count >= MaxKnots) ? MaxKnots - 1 : pred_count;
    pred_x[idx] = k.x;
    pred_y[idx] = k.y;
    if (idx > 0 && k.x <= pred_x[idx-1]) pred_error = 1;
    pred_count = idx + 1;
    if (k.last || pred_count >= MaxKnots) begin
      compute_tangents(pred_count);
      pred_count = 0;
      pred_error = 0;
      runs_done++;
    end
  endtask

  function automatic int pick_gap();
    if ($urandom_range(0, 2) == 0) return 0;
    if ($urandom_range(0, 9) == 0) return $urandom_range(10, 60);
    return $urandom_range(1, 3);
  endfunction

  // Sender: presents queued knots with random gaps between transfers.
  // A new knot is offered only after the previous one was taken at a rising edge.
  int send_gap;
  bit in_taken;
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      send_gap = 0;
    end else if (!in_valid_i || in_taken) begin
      if (send_gap > 0) begin
        send_gap--;
        in_valid_i <= 1'b0;
      end else if (pending_knots.size() > 0) begin
        knot_x_i     <= pending_knots[0].x;
        knot_y_i     <= pending_knots[0].y;
        final_knot_i <= pending_knots[0].last;
        in_valid_i   <= 1'b1;
        void'(pending_knots.pop_front());
        send_gap = pick_gap();
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Receiver backpressure.
  int stall_left;
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      stall_left = 0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= 1'b1;
      if ($urandom_range(0, 3) == 0) stall_left = pick_gap();
    end
  end

  // Monitor: predict on input transfers, check on output transfers.
  always @(posedge clk_i) begin
    knot_t    k;
    tangent_t e;
    in_taken = rst_ni && in_valid_i && in_ready_o;
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        k.x = knot_x_i;
        k.y = knot_y_i;
        k.last = final_knot_i;
        absorb_knot(k);
        knots_sent++;
      end
      if (out_valid_o && out_ready_i) begin
        tangents_seen++;
        if (expected_tangents.size() == 0) begin
          $error("unexpected tangent transfer, index %0d", knot_index_o);
          errors++;
        end else begin
          e = expected_tangents.pop_front();
          if (knot_index_o !== e.index) begin
            $error("knot_index expected %0d got %0d", e.index, knot_index_o);
            errors++;
          end
          if (slope_o !== e.slope) begin
            $error("slope expected %0d got %0d", e.slope, slope_o);
            errors++;
          end
          if (run_end_o !== e.run_end) begin
            $error("run_end expected %0d got %0d", e.run_end, run_end_o);
            errors++;
          end
          if (spacing_error_o !== e.spacing_err) begin
            $error("spacing_error expected %0d got %0d", e.spacing_err, spacing_error_o);
            errors++;
          end
        end
      end
    end
  end

  task automatic write_threshold(logic [15:0] value);
    @(negedge clk_i);
    psel <= 1'b1;
    pwrite <= 1'b1;
    paddr <= {mtc_pkg::REG_FLAT_THRESHOLD, 2'b00};
    pwdata <= {16'h0, value};
    @(negedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    pred_flat = value;
  endtask

  task automatic add_knot(logic signed [31:0] x, logic signed [31:0] y, logic last);
    knot_t k;
    k.x = x;
    k.y = y;
    k.last = last;
    pending_knots.push_back(k);
  endtask

  // Queues a run of n knots, mostly increasing x with random steps.
  task automatic add_random_run(int n, bit noisy);
    logic signed [31:0] x;
    logic signed [31:0] y;
    x = $urandom_range(0, 3) == 0 ? 32'($urandom) : -32'sd100000 * $urandom_range(0, 50);
    y = $urandom_range(0, 3) == 0 ? 32'($urandom) : 32'sd0;
    for (int i = 0; i < n; i++) begin
      add_knot(x, y, i == n - 1);
      if (noisy && $urandom_range(0, 4) == 0) x = 32'($urandom);
      else x = x + $urandom_range(1, 1 << $urandom_range(1, 20));
      case ($urandom_range(0, 3))
        0: y = 32'($urandom);
        1: y = y + $urandom_range(0, 1 << $urandom_range(0, 24));
        2: y = y - $urandom_range(0, 1 << $urandom_range(0, 24));
        default: y = y + $urandom_range(0, 3);
      endcase
    end
  endtask

  // Waits until every expected tangent has arrived, then lets the unit settle.
  task automatic drain();
    while (pending_knots.size() > 0 || in_valid_i || expected_tangents.size() > 0)
      @(posedge clk_i);
    repeat (200) @(posedge clk_i);
  endtask

  initial begin
    clk_i = 1'b0;
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    out_ready_i = 1'b0;
    knot_x_i = '0;
    knot_y_i = '0;
    final_knot_i = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    errors = 0;
    knots_sent = 0;
    tangents_seen = 0;
    runs_done = 0;
    pred_count = 0;
    pred_error = 0;
    pred_flat = mtc_pkg::FLAT_THRESHOLD_RST;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed: single knot, two knots, extremes, non-increasing x, flat and steep runs.
    add_knot(32'sh80000000, 32'sh7fffffff, 1'b1);
    add_knot(0, 0, 1'b0);
    add_knot(65536, 32'sh7fffffff, 1'b1);
    add_knot(32'sh80000000, 32'sh80000000, 1'b0);
    add_knot(32'sh80000001, 32'sh7fffffff, 1'b0);
    add_knot(32'sh7fffffff, 32'sh80000000, 1'b0);
    add_knot(32'sh7fffffff, 0, 1'b1);
    add_knot(0, 0, 1'b0);
    add_knot(65536, 0, 1'b0);
    add_knot(131072, 65536, 1'b0);
    add_knot(196608, 65536 * 40, 1'b0);
    add_knot(262144, 65536 * 41, 1'b0);
    add_knot(327680, 65536 * 41, 1'b0);
    add_knot(393216, 0, 1'b1);
    add_knot(100, 5, 1'b0);
    add_knot(200, 50000, 1'b0);
    add_knot(300, 50000, 1'b0);
    add_knot(301, 50001, 1'b1);
    drain();

    // A full store ends the run without a final flag.
    write_threshold(16'hffff);
    for (int i = 0; i < MaxKnots; i++) add_knot(i * 70000, (i % 5) * 90000, 1'b0);
    drain();

    write_threshold(16'd0);
    for (int i = 0; i < 6; i++) add_random_run($urandom_range(1, 10), 0);
    drain();

    write_threshold(16'($urandom));
    for (int i = 0; i < 5; i++) add_random_run($urandom_range(2, 8), $urandom_range(0, 1));
    drain();

    write_threshold(mtc_pkg::FLAT_THRESHOLD_RST);
    for (int i = 0; i < 3; i++) add_random_run($urandom_range(3, 12), i == 2);
    drain();

    $display("Covered %0d knot transfers in %0d runs, %0d tangents checked.",
             knots_sent, runs_done, tangents_seen);
    $display("Threshold settings exercised: reset, zero, full scale and random.");
    if (errors == 0) begin
      $display("monotone_tangent_calculator_unit_tb passed");
    end else begin
      $display("monotone_tangent_calculator_unit_tb failed");
    end
    $finish;
  end

  // Watchdog on the whole run.
  initial begin
    #20000000;
    $display("monotone_tangent_calculator_unit_tb failed");
    $finish;
  end

endmodule

/* sim.f */
+incdir+rtl
rtl/mtc_pkg.sv
rtl/mtc_unit.sv
rtl/mtc_ctrl.sv
rtl/monotone_tangent_calculator_unit.sv
bench/monotone_tangent_calculator_unit_tb.sv
